### src/bmime_pkg.sv
package bmime_pkg;

  // Configuration register indexes
  localparam logic REG_LINE_LIMIT  = 1'b0;
  localparam logic REG_HEADER_MODE = 1'b1;

  // Reset values and counter limits
  localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;
  localparam logic [7:0] COUNT_START      = 8'd4;
  localparam logic [7:0] COUNT_MAX        = 8'hFF;

  // Special characters
  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Default depth of the group queue
  localparam int GRP_FIFO_DEPTH = 2;

  // One closed group handed from the front to the back
  typedef struct packed {
    logic [23:0] word;    // three bytes, first byte in the top bits
    logic [1:0]  nbytes;  // real bytes in the group, 1 to 3
    logic        crlf;    // append a line break after the group
  } grp_t;

  // Map a 6-bit value onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

### src/bmime_front.sv
module bmime_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output bmime_pkg::grp_t   q_data_o
);
  import bmime_pkg::*;

  logic [7:0]  limit_q;
  logic        hdr_q;
  logic [15:0] held_q, held_d;
  logic [1:0]  fill_q, fill_d;
  logic [7:0]  lcount_q, lcount_d;

  logic        accept;
  logic        closes;
  logic [8:0]  sum;
  logic [7:0]  sat;
  logic        crlf;
  logic [23:0] word;

  // Accept a byte whenever the queue can take a group
  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign closes     = last_byte_i | (fill_q == 2'd2);

  // Assemble the group word from held bytes and the new byte
  always_comb begin
    case (fill_q)
      2'd0:    word = {data_byte_i, 16'h0000};
      2'd1:    word = {held_q[15:8], data_byte_i, 8'h00};
      default: word = {held_q, data_byte_i};
    endcase
  end

  // Advance the line counter with saturation and decide on a break
  assign sum  = {1'b0, lcount_q} + 9'd4;
  assign sat  = sum[8] ? COUNT_MAX : sum[7:0];
  assign crlf = ~hdr_q & (sat > limit_q);

  assign q_push_o        = accept & closes;
  assign q_data_o.word   = word;
  assign q_data_o.nbytes = (fill_q == 2'd0) ? 2'd1 : ((fill_q == 2'd1) ? 2'd2 : 2'd3);
  assign q_data_o.crlf   = crlf;

  // Hold partial groups; on group close, clear them and update the line counter
  always_comb begin
    held_d   = held_q;
    fill_d   = fill_q;
    lcount_d = lcount_q;
    if (accept) begin
      if (!closes) begin
        if (fill_q == 2'd0) begin
          held_d = {data_byte_i, 8'h00};
        end else begin
          held_d = {held_q[15:8], data_byte_i};
        end
        fill_d = fill_q + 2'd1;
      end else begin
        held_d   = 16'h0000;
        fill_d   = 2'd0;
        lcount_d = (crlf | last_byte_i) ? COUNT_START : sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LINE_LIMIT_RESET;
      hdr_q    <= 1'b0;
      held_q   <= 16'h0000;
      fill_q   <= 2'd0;
      lcount_q <= COUNT_START;
    end else begin
      held_q   <= held_d;
      fill_q   <= fill_d;
      lcount_q <= lcount_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINE_LIMIT:  limit_q <= cfg_wdata_i;
          REG_HEADER_MODE: hdr_q   <= cfg_wdata_i[0];
          default:         limit_q <= limit_q;
        endcase
      end
    end
  end

endmodule

### src/bmime_fifo.sv
module bmime_fifo #(
  parameter int DEPTH = bmime_pkg::GRP_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bmime_pkg::grp_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output bmime_pkg::grp_t   pop_data_o
);
  import bmime_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rptr_q];

  // Store groups
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

### src/bmime_back.sv
module bmime_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  bmime_pkg::grp_t   q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              end_of_output_o
);
  import bmime_pkg::*;

  localparam logic [2:0] POS_C0 = 3'd0;
  localparam logic [2:0] POS_C1 = 3'd1;
  localparam logic [2:0] POS_C2 = 3'd2;
  localparam logic [2:0] POS_C3 = 3'd3;
  localparam logic [2:0] POS_CR = 3'd4;
  localparam logic [2:0] POS_LF = 3'd5;

  grp_t       cur_q;
  logic       active_q;
  logic [2:0] pos_q;
  logic       at_last;
  logic       done;

  assign at_last = cur_q.crlf ? (pos_q == POS_LF) : (pos_q == POS_C3);
  assign done    = active_q & out_ready_i & at_last;
  assign q_pop_o = (~active_q | done) & ~q_empty_i;

  // Select the character for the current position
  always_comb begin
    case (pos_q)
      POS_C0:  out_char_o = b64_char(cur_q.word[23:18]);
      POS_C1:  out_char_o = b64_char(cur_q.word[17:12]);
      POS_C2:  out_char_o = (cur_q.nbytes >= 2'd2) ? b64_char(cur_q.word[11:6]) : CHAR_PAD;
      POS_C3:  out_char_o = (cur_q.nbytes == 2'd3) ? b64_char(cur_q.word[5:0]) : CHAR_PAD;
      POS_CR:  out_char_o = CHAR_CR;
      default: out_char_o = CHAR_LF;
    endcase
  end

  assign out_valid_o     = active_q;
  assign end_of_output_o = at_last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Walk through the characters of a group, load the next one at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= POS_C0;
    end else begin
      if (q_pop_o) begin
        active_q <= 1'b1;
        pos_q    <= POS_C0;
      end else if (done) begin
        active_q <= 1'b0;
        pos_q    <= POS_C0;
      end else if (active_q && out_ready_i) begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

endmodule

### src/base64_mime_encoder_unit.sv
// The group closed by an accepted byte is first written into the group queue,
// then loaded into the output stage before its first character is offered.
// The output emits one character per cycle while out_ready_i is high, four per
// group or six with a line break.
// The group queue (FIFO_DEPTH entries) lets input run ahead while output stalls.
// Reset clears held bytes, the line counter (to 4) and the queue, and restores the config.
module base64_mime_encoder_unit #(
  parameter int FIFO_DEPTH = bmime_pkg::GRP_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       end_of_output_o
);
  import bmime_pkg::*;

  grp_t push_data, pop_data;
  logic q_push, q_full, q_pop, q_empty;

  // Gather bytes into groups and decide line breaks
  bmime_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data)
  );

  // Queue closed groups
  bmime_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // Emit characters one per cycle while out_ready_i is high
  bmime_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (pop_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .end_of_output_o (end_of_output_o)
  );

  // A line break never ends a request's output halfway
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_output_o |-> out_char_o != CHAR_CR)
    else $error("end_of_output on CR");

  // CR is always followed directly by LF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_char_o == CHAR_CR |=>
      out_valid_o && out_char_o == CHAR_LF)
    else $error("CR not followed by LF");

  // A group is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full group queue");

endmodule

### test/b64_stream_checker.sv
`timescale 1ns / 100ps

module b64_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic       end_of_output_i,
  output int         fail_count_o,
  output int         pending_o
);
  import bmime_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoo;
  } enc_char_t;

  // Alphabet packed as one vector, index 0 in the top byte
  localparam logic [8*64-1:0] ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   char_q[$];
  logic [15:0] held;
  logic [1:0]  fill;
  logic [7:0]  line_cnt;
  logic [7:0]  limit;
  logic        hdr;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int pos;
    pos = 63 - int'(v);
    return ALPHA[8*pos +: 8];
  endfunction

  // Count a failure and report the first few
  task automatic note_mismatch(input logic [7:0] exp_ch, input logic exp_eoo,
                               input bit none_waiting);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      if (none_waiting) begin
        $display("%0t: extra char %h end %b with nothing expected",
                 $realtime, out_char_i, end_of_output_i);
      end else begin
        $display("%0t: char exp %h got %h, end exp %b got %b",
                 $realtime, exp_ch, out_char_i, exp_eoo, end_of_output_i);
      end
    end
  endtask

  // Advance the encoder state by one byte and queue the characters it yields
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] word;
    logic [1:0]  nb;
    logic [8:0]  sum;
    logic [7:0]  ch[6];
    int          n;
    nb = fill + 2'd1;
    if (nb < 2'd3 && !last) begin
      if (fill == 2'd0) begin
        held = {b, 8'h00};
      end else begin
        held[7:0] = b;
      end
      fill = nb;
      return;
    end
    case (nb)
      2'd1:    word = {b, 16'h0000};
      2'd2:    word = {held[15:8], b, 8'h00};
      default: word = {held, b};
    endcase
    ch[0] = sextet_char(word[23:18]);
    ch[1] = sextet_char(word[17:12]);
    ch[2] = (nb >= 2'd2) ? sextet_char(word[11:6]) : CHAR_PAD;
    ch[3] = (nb == 2'd3) ? sextet_char(word[5:0]) : CHAR_PAD;
    n = 4;
    // Saturate the line counter at its ceiling
    sum = {1'b0, line_cnt} + 9'd4;
    line_cnt = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[7:0];
    if (!hdr && line_cnt > limit) begin
      ch[4] = CHAR_CR;
      ch[5] = CHAR_LF;
      n = 6;
      line_cnt = COUNT_START;
    end
    held = '0;
    fill = '0;
    if (last) begin
      line_cnt = COUNT_START;
    end
    for (int i = 0; i < n; i++) begin
      char_q.push_back('{ch: ch[i], eoo: (i == n - 1)});
    end
  endtask

  // Track config, check each accepted character, then predict from each request
  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t exp_c;
    if (!rst_ni) begin
      char_q.delete();
      held = '0;
      fill = '0;
      line_cnt = COUNT_START;
      limit = LINE_LIMIT_RESET;
      hdr = 1'b0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LINE_LIMIT) begin
          limit = cfg_wdata_i;
        end else begin
          hdr = cfg_wdata_i[0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (char_q.size() == 0) begin
          note_mismatch(8'h00, 1'b0, 1'b1);
        end else begin
          exp_c = char_q.pop_front();
          if (exp_c.ch !== out_char_i || exp_c.eoo !== end_of_output_i) begin
            note_mismatch(exp_c.ch, exp_c.eoo, 1'b0);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        encode_byte(data_byte_i, last_byte_i);
      end
      pending_o = char_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bmime_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       end_of_output;

  int fail_count;
  int pending;
  int cycles = 0;
  int hold_cnt = 0;
  int run_cnt = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  bit no_idle = 1'b0;

  always #2 clk = ~clk;

  base64_mime_encoder_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_char_o      (out_char),
    .end_of_output_o (end_of_output)
  );

  b64_stream_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_char_i      (out_char),
    .end_of_output_i (end_of_output),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sender gap: mostly none or short, a few long
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 15) < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (no_idle || run_cnt > 0) begin
      if (run_cnt > 0) run_cnt <= run_cnt - 1;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_cnt <= stall_len();
      out_ready <= 1'b0;
    end else begin
      run_cnt <= $urandom_range(0, 15);
      out_ready <= 1'b1;
    end
  end

  // Offer one byte and hold it until accepted
  task automatic offer_byte(input logic [7:0] b, input logic last);
    int   gap;
    logic took;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_message(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      offer_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
  endtask

  // Random messages; a few are left open across the next phase
  task automatic random_traffic(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      if (len > n_items - sent) len = n_items - sent;
      send_message(len, $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  // Drop valid and wait until every expected character is out
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] limit, input logic hdr);
    write_reg(REG_LINE_LIMIT, limit);
    write_reg(REG_HEADER_MODE, {7'b0, hdr});
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Padding cases, field extremes and the '+' and '/' characters
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h80, 1'b1);
    offer_byte(8'hFB, 1'b0);
    offer_byte(8'hEF, 1'b0);
    offer_byte(8'hBE, 1'b1);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h55, 1'b1);

    // Small limit: break after every group, also after the final one
    quiesce();
    set_config(8'd4, 1'b0);
    offer_byte(8'h12, 1'b0);
    offer_byte(8'h34, 1'b0);
    offer_byte(8'h56, 1'b0);
    offer_byte(8'hAA, 1'b1);

    // Largest limit: no break
    quiesce();
    set_config(8'd255, 1'b0);
    send_message(8, 1'b1);

    // Default limit with a long receiver hold-off
    quiesce();
    set_config(LINE_LIMIT_RESET, 1'b0);
    long_hold_req <= 1'b1;
    random_traffic(20);

    // Zero limit
    quiesce();
    set_config(8'd0, 1'b0);
    random_traffic(8);

    // Header mode: let the counter grow past the limit within one message
    quiesce();
    set_config(8'd20, 1'b1);
    send_message(24, 1'b0);

    // Clear header mode: the grown count breaks after the first group
    quiesce();
    set_config(8'd32, 1'b0);
    send_message(6, 1'b1);

    // Random settings
    for (int p = 0; p < 3; p++) begin
      quiesce();
      set_config(8'($urandom_range(4, 40)), 1'($urandom_range(0, 1)));
      random_traffic(6);
    end

    // No idling on either side
    quiesce();
    set_config(8'd12, 1'b0);
    no_idle <= 1'b1;
    random_traffic(10);

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
